[design/lr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types, widths and codes of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_BITS = 10;
  localparam int COLOR_BITS = 24;
  // signed delta, doubled delta and decision widths
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int TWICE_BITS = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 4;

  // stream word layouts
  localparam int IN_USED_BITS  = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;
  localparam int OUT_USED_BITS = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_USED_BITS;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic [COLOR_BITS-1:0]        color_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [TWICE_BITS-1:0] twice_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,
    OCT_STEEP_UP     = 2'd1,
    OCT_STEEP_DOWN   = 2'd2,
    OCT_SHALLOW_DOWN = 2'd3
  } octant_e;

  typedef struct packed {
    cmd_e   cmd;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } pixel_t;

endpackage

[design/lr_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_in_stage
// Input register: takes one word per cycle while its slot is free and holds it for the step core.
// ----------------------------------------------------------------------------
module lr_in_stage
  import lr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_DATA_BITS-1:0] s_tdata,
  input  logic [0:0]              s_tuser,
  input  logic                    advance,
  output logic                    in_valid,
  output item_t                   item
);

  logic  in_valid_next;
  logic  take;
  item_t item_next;

  // the slot frees up whenever the held word moves on
  assign s_tready = !in_valid || advance;
  assign take     = s_tvalid && s_tready;

  // unpack the word
  always_comb begin
    item_next.cmd        = cmd_e'(s_tuser[0]);
    item_next.start_x    = s_tdata[COORD_BITS-1:0];
    item_next.start_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    item_next.end_x      = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    item_next.end_y      = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    item_next.line_color = s_tdata[IN_USED_BITS-1:4*COORD_BITS];
  end

  assign in_valid_next = take || (in_valid && !advance);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

[design/lr_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_core
// Line state and one Bresenham step per cycle while advance is high; loads a line on start.
// ----------------------------------------------------------------------------
module lr_core
  import lr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  item_t  item,
  output logic   res_valid,
  output pixel_t res
);

  coord_t  cur_x, cur_y, stop_x, stop_y;
  dec_t    decision;
  twice_t  twice_dy, twice_neg_dx;
  octant_e octant_pair;
  logic    active;
  color_t  held_color;

  coord_t  cur_x_next, cur_y_next, stop_x_next, stop_y_next;
  dec_t    decision_next;
  twice_t  twice_dy_next, twice_neg_dx_next;
  octant_e octant_pair_next;
  logic    active_next;
  color_t  held_color_next;

  // start path
  logic    swap;
  coord_t  x0, y0, x1, y1;
  delta_t  dy, dx;
  octant_e sel_pair;
  dec_t    init_dec;
  logic    start_more;

  // step path
  logic    minor;
  coord_t  step_x, step_y;
  dec_t    step_dec;
  logic    step_more;

  // order endpoints so x rises, then classify the slope
  always_comb begin
    swap = item.start_x > item.end_x;
    x0   = swap ? item.end_x   : item.start_x;
    y0   = swap ? item.end_y   : item.start_y;
    x1   = swap ? item.start_x : item.end_x;
    y1   = swap ? item.start_y : item.end_y;
    dy   = delta_t'({1'b0, y1}) - delta_t'({1'b0, y0});
    dx   = delta_t'({1'b0, x1}) - delta_t'({1'b0, x0});
    if (dy > 0 && dy <= dx) begin
      sel_pair = OCT_SHALLOW_UP;
      init_dec = (dec_t'(dy) <<< 1) - dec_t'(dx);
    end else if (dy > dx) begin
      sel_pair = OCT_STEEP_UP;
      init_dec = dec_t'(dy) - (dec_t'(dx) <<< 1);
    end else if (dy < -dx) begin
      sel_pair = OCT_STEEP_DOWN;
      init_dec = dec_t'(dy) + (dec_t'(dx) <<< 1);
    end else begin
      sel_pair = OCT_SHALLOW_DOWN;
      init_dec = (dec_t'(dy) <<< 1) + dec_t'(dx);
    end
    unique case (sel_pair)
      OCT_STEEP_UP:   start_more = y0 < y1;
      OCT_STEEP_DOWN: start_more = y0 > y1;
      default:        start_more = x0 < x1;
    endcase
  end

  // one step: optional minor move, then the major move
  always_comb begin
    step_x   = cur_x;
    step_y   = cur_y;
    step_dec = decision;
    unique case (octant_pair)
      OCT_SHALLOW_UP: begin
        minor = decision > 0;
        if (minor) begin
          step_y   = cur_y + 1'b1;
          step_dec = step_dec + dec_t'(twice_neg_dx);
        end
        step_x   = cur_x + 1'b1;
        step_dec = step_dec + dec_t'(twice_dy);
      end
      OCT_STEEP_UP: begin
        minor = decision < 0;
        if (minor) begin
          step_x   = cur_x + 1'b1;
          step_dec = step_dec + dec_t'(twice_dy);
        end
        step_y   = cur_y + 1'b1;
        step_dec = step_dec + dec_t'(twice_neg_dx);
      end
      OCT_STEEP_DOWN: begin
        minor = decision > 0;
        if (minor) begin
          step_x   = cur_x + 1'b1;
          step_dec = step_dec + dec_t'(twice_dy);
        end
        step_y   = cur_y - 1'b1;
        step_dec = step_dec - dec_t'(twice_neg_dx);
      end
      default: begin
        minor = decision < 0;
        if (minor) begin
          step_y   = cur_y - 1'b1;
          step_dec = step_dec - dec_t'(twice_neg_dx);
        end
        step_x   = cur_x + 1'b1;
        step_dec = step_dec + dec_t'(twice_dy);
      end
    endcase
    unique case (octant_pair)
      OCT_STEEP_UP:   step_more = step_y < stop_y;
      OCT_STEEP_DOWN: step_more = step_y > stop_y;
      default:        step_more = step_x < stop_x;
    endcase
  end

  // next state and result
  always_comb begin
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    stop_x_next       = stop_x;
    stop_y_next       = stop_y;
    decision_next     = decision;
    twice_dy_next     = twice_dy;
    twice_neg_dx_next = twice_neg_dx;
    octant_pair_next  = octant_pair;
    active_next       = active;
    held_color_next   = held_color;
    res_valid         = 1'b0;
    if (advance) begin
      if (item.cmd == CMD_START) begin
        cur_x_next        = x0;
        cur_y_next        = y0;
        stop_x_next       = x1;
        stop_y_next       = y1;
        decision_next     = init_dec;
        twice_dy_next     = twice_t'(dy) <<< 1;
        twice_neg_dx_next = -(twice_t'(dx) <<< 1);
        octant_pair_next  = sel_pair;
        active_next       = start_more;
        held_color_next   = item.line_color;
      end else if (active) begin
        cur_x_next    = step_x;
        cur_y_next    = step_y;
        decision_next = step_dec;
        active_next   = step_more;
        res_valid     = 1'b1;
      end
    end
    res.pixel_x     = cur_x;
    res.pixel_y     = cur_y;
    res.pixel_color = held_color;
    res.last_pixel  = !step_more;
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      stop_x       <= '0;
      stop_y       <= '0;
      decision     <= '0;
      twice_dy     <= '0;
      twice_neg_dx <= '0;
      octant_pair  <= OCT_SHALLOW_UP;
      active       <= 1'b0;
      held_color   <= '0;
    end else begin
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      stop_x       <= stop_x_next;
      stop_y       <= stop_y_next;
      decision     <= decision_next;
      twice_dy     <= twice_dy_next;
      twice_neg_dx <= twice_neg_dx_next;
      octant_pair  <= octant_pair_next;
      active       <= active_next;
      held_color   <= held_color_next;
    end
  end

endmodule

[design/lr_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_out_stage
// Result register: holds one pixel word until the sink takes it.
// ----------------------------------------------------------------------------
module lr_out_stage
  import lr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     res_valid,
  input  pixel_t                   res,
  output logic                     out_free,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  output logic                     m_tlast
);

  logic   m_tvalid_next;
  pixel_t pixel;

  // free when empty or being taken this cycle
  assign out_free      = !m_tvalid || m_tready;
  assign m_tvalid_next = advance ? res_valid : (m_tvalid && !m_tready);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      pixel <= res;
    end
  end

  // pack the word
  assign m_tdata = {{OUT_PAD_BITS{1'b0}}, pixel.pixel_color, pixel.pixel_y, pixel.pixel_x};
  assign m_tlast = pixel.last_pixel;

endmodule

[design/line_rasterizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line rasterizer for all octants, one pixel per step word of an active line.
//
//   channel  dir  signals                      word
//   s_       in   tvalid tready tdata tuser    start or step command
//   m_       out  tvalid tready tdata tlast    one pixel
//
// One input word is taken every cycle while the sink keeps up; a step word's
// pixel passes the input register, then the result register, before it shows on m_.
// The rate is set by the single step in the core (up to two decision adds and
// one end compare per step).
// rst is synchronous and leaves the block idle with both stages empty.
// A stalled sink holds the pixel word; the input register then fills and
// s_tready drops until the pixel is taken.
// ----------------------------------------------------------------------------
module line_rasterizer
  import lr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // cmd
  input  logic [0:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // last_pixel
  output logic                     m_tlast
);

  logic   in_valid;
  item_t  item;
  logic   out_free;
  logic   advance;
  logic   res_valid;
  pixel_t res;

  // a held word moves on when the result register can take its outcome
  assign advance = in_valid && out_free;

  lr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_valid (in_valid),
    .item     (item)
  );

  lr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  lr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

[design/lr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lr_checker
  import lr_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [IN_DATA_BITS-1:0]  s_tdata,
  input logic [0:0]               s_tuser,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata,
  input logic                     m_tlast
);

  // reset leaves no pixel pending and the input open
  assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("pixel pending or input closed after reset");

  // a stalled pixel word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled pixel word changed");

  // with the result register empty the input never stalls
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // a pixel taken this cycle frees room for a new word
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tready |-> s_tready)
    else $error("input stalled while pixel word was taken");

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);

[tb/line_rasterizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_test
// Self-checking bench for the line rasterizer. Start and step words are
// driven on the input stream. A scoreboard tracks the line state, works out
// each pixel that a step word must produce and compares it field by field
// with the output stream. Short directed lines come first. Random lines
// follow, run with and without idle cycles on the source, stalls on the
// sink, and a long sink hold-off.
// ----------------------------------------------------------------------------
module line_rasterizer_test;
  import lr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

  // tracks the line being drawn and the pixels still owed by the block
  class pixel_scoreboard;
    coord_t  cur_x, cur_y, stop_x, stop_y;
    dec_t    decision;
    twice_t  twice_dy, twice_neg_dx;
    octant_e octant;
    bit      active;
    color_t  color;
    pixel_t  owed_q[$];
    int      mismatches;
    int      pixels_checked;
    int      lines_started;
    int      words_taken;

    function new();
      octant = OCT_SHALLOW_UP;
      active = 1'b0;
      cur_x = '0; cur_y = '0; stop_x = '0; stop_y = '0;
      decision = '0; twice_dy = '0; twice_neg_dx = '0; color = '0;
    endfunction

    function bit more_pixels();
      case (octant)
        OCT_STEEP_UP:   return cur_y < stop_y;
        OCT_STEEP_DOWN: return cur_y > stop_y;
        default:        return cur_x < stop_x;
      endcase
    endfunction

    // called for every input word the block takes
    function void note_word(item_t it);
      int x0, y0, x1, y1, dy, ndx, t;
      pixel_t px;
      words_taken++;
      if (it.cmd == CMD_START) begin
        x0 = int'(it.start_x); y0 = int'(it.start_y);
        x1 = int'(it.end_x);   y1 = int'(it.end_y);
        // make x rise along the line
        if (x0 > x1) begin
          t = x0; x0 = x1; x1 = t;
          t = y0; y0 = y1; y1 = t;
        end
        dy  = y1 - y0;
        ndx = x0 - x1;
        if (dy > 0 && dy <= -ndx) begin
          octant = OCT_SHALLOW_UP;
          decision = dec_t'(2 * dy + ndx);
        end else if (dy > -ndx) begin
          octant = OCT_STEEP_UP;
          decision = dec_t'(dy + 2 * ndx);
        end else if (dy < ndx) begin
          octant = OCT_STEEP_DOWN;
          decision = dec_t'(dy - 2 * ndx);
        end else begin
          octant = OCT_SHALLOW_DOWN;
          decision = dec_t'(2 * dy - ndx);
        end
        twice_dy     = twice_t'(2 * dy);
        twice_neg_dx = twice_t'(2 * ndx);
        cur_x  = coord_t'(x0); cur_y  = coord_t'(y0);
        stop_x = coord_t'(x1); stop_y = coord_t'(y1);
        color  = it.line_color;
        active = more_pixels();
        lines_started++;
      end else if (active) begin
        px.pixel_x     = cur_x;
        px.pixel_y     = cur_y;
        px.pixel_color = color;
        // minor step on strict sign only, ties keep the major axis
        case (octant)
          OCT_SHALLOW_UP: begin
            if (decision > 0) begin
              cur_y++;
              decision += dec_t'(twice_neg_dx);
            end
            cur_x++;
            decision += dec_t'(twice_dy);
          end
          OCT_STEEP_UP: begin
            if (decision < 0) begin
              cur_x++;
              decision += dec_t'(twice_dy);
            end
            cur_y++;
            decision += dec_t'(twice_neg_dx);
          end
          OCT_STEEP_DOWN: begin
            if (decision > 0) begin
              cur_x++;
              decision += dec_t'(twice_dy);
            end
            cur_y--;
            decision -= dec_t'(twice_neg_dx);
          end
          default: begin
            if (decision < 0) begin
              cur_y--;
              decision -= dec_t'(twice_neg_dx);
            end
            cur_x++;
            decision += dec_t'(twice_dy);
          end
        endcase
        active = more_pixels();
        px.last_pixel = !active;
        owed_q.push_back(px);
      end
    endfunction

    // called for every pixel word the block hands out
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      pixels_checked++;
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
        mismatches++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
        mismatches++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
        mismatches++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $error("last_pixel: expected %0d, got %0d", want.last_pixel, got.last_pixel);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic [0:0]               s_tuser = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic                     m_tlast;

  pixel_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  line_rasterizer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // pixel sink: check taken words, then pick next ready
  always @(posedge clk) begin
    pixel_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.pixel_x     = m_tdata[COORD_BITS-1:0];
      got.pixel_y     = m_tdata[2*COORD_BITS-1:COORD_BITS];
      got.pixel_color = m_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS];
      got.last_pixel  = m_tlast;
      sb.check_pixel(got);
    end
    if (hold_request && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // drive one word and wait until it is taken
  task automatic send_word(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.line_color, it.end_y, it.end_x, it.start_y, it.start_x};
    s_tuser  <= it.cmd;
    do @(posedge clk); while (!s_tready);
    sb.note_word(it);
  endtask

  // step word with random content in the unused fields
  function automatic item_t step_word();
    item_t it;
    it.cmd        = CMD_STEP;
    it.start_x    = coord_t'($urandom);
    it.start_y    = coord_t'($urandom);
    it.end_x      = coord_t'($urandom);
    it.end_y      = coord_t'($urandom);
    it.line_color = color_t'($urandom);
    return it;
  endfunction

  // start word followed by a number of step words
  task automatic send_line(input int x0, y0, x1, y1, input color_t c, input int steps);
    item_t it;
    it.cmd        = CMD_START;
    it.start_x    = coord_t'(x0);
    it.start_y    = coord_t'(y0);
    it.end_x      = coord_t'(x1);
    it.end_y      = coord_t'(y1);
    it.line_color = c;
    send_word(it);
    repeat (steps) send_word(step_word());
  endtask

  // random line, mostly short, sometimes cut off by the next start
  task automatic random_line();
    int x0, y0, x1, y1, dx, dy, span, len, steps, r;
    r  = $urandom_range(99);
    x0 = $urandom_range(COORD_MAX);
    y0 = $urandom_range(COORD_MAX);
    if ($urandom_range(9) == 0) x0 = $urandom_range(1) ? COORD_MAX : 0;
    if ($urandom_range(9) == 0) y0 = $urandom_range(1) ? COORD_MAX : 0;
    if (r < 8) begin
      x1 = x0;
      y1 = y0;
    end else if (r < 18) begin
      x1 = $urandom_range(COORD_MAX);
      y1 = $urandom_range(COORD_MAX);
    end else begin
      span = $urandom_range(1, 16);
      case ($urandom_range(5))
        0: begin dx = span; dy = 0;     end
        1: begin dx = 0;    dy = span;  end
        2: begin dx = span; dy = span;  end
        3: begin dx = span; dy = -span; end
        default: begin
          dx = $urandom_range(32) - 16;
          dy = $urandom_range(32) - 16;
        end
      endcase
      if ($urandom_range(1)) begin
        dx = -dx;
        dy = -dy;
      end
      x1 = x0 + dx;
      if (x1 < 0 || x1 > COORD_MAX) x1 = x0 - dx;
      y1 = y0 + dy;
      if (y1 < 0 || y1 > COORD_MAX) y1 = y0 - dy;
    end
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
    len = (dx > dy) ? dx : dy;
    // some lines are abandoned early, others get idle steps after the end
    if (len > 0 && $urandom_range(99) < 15) steps = $urandom_range(len - 1);
    else steps = len + $urandom_range(2);
    if (steps > 48 && $urandom_range(9) != 0) steps = $urandom_range(8, 48);
    send_line(x0, y0, x1, y1, color_t'($urandom), steps);
  endtask

  task automatic run_phase(input int idle, stall, count, input bit squeeze);
    int goal;
    idle_pct  = idle;
    stall_pct = stall;
    goal = sb.words_taken + count;
    if (squeeze) hold_request = 1'b1;
    while (sb.words_taken < goal) random_line();
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines
    send_word(step_word());                                  // step while idle
    send_line(5, 5, 5, 5, 24'h000000, 1);                    // zero length
    send_line(0, 0, 3, 3, 24'hFFFFFF, 3);                    // diagonal tie, shallow up
    send_line(COORD_MAX, 0, COORD_MAX, 2, 24'h000000, 2);    // vertical, steep up
    send_line(0, COORD_MAX, 1, COORD_MAX - 3, 24'hA5A5A5, 3); // steep down
    send_line(COORD_MAX, 0, COORD_MAX - 3, 3, 24'h5A5A5A, 3); // swapped, tie shallow down
    send_line(COORD_MAX, COORD_MAX, 0, 0, 24'h123456, 2);    // full span, abandoned
    send_line(0, 0, 2, 1, 24'hFEDCBA, 3);                    // restart, one idle step

    // random lines under different flow conditions
    run_phase(0, 0, 500, 1'b0);
    run_phase(84, 0, 400, 1'b0);
    run_phase(0, 84, 400, 1'b0);
    run_phase(20, 20, 350, 1'b0);
    run_phase(0, 0, 200, 1'b1);

    s_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d pixels from %0d lines, %0d words taken",
             sb.pixels_checked, sb.lines_started, sb.words_taken);
    $display("flow: free running, source gaps, sink stalls, both, long sink hold-off");
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
